@@ rtl/block_average_spread_reject_defines.svh @@
// Assertion macros used by the checker of this block.
`ifndef BLOCK_AVERAGE_SPREAD_REJECT_DEFINES_SVH
`define BLOCK_AVERAGE_SPREAD_REJECT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BAS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("block average check failed");

// Consequent must hold in the cycle after the antecedent.
`define BAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error("block average sequence check failed");

`endif

@@ rtl/bas_pkg.sv @@
`default_nettype none

package bas_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned REG_W     = 12;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_SPREAD_LIMIT = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR        = 1'd1;

  localparam logic [REG_W-1:0] SPREAD_LIMIT_RESET = 12'd300;
  localparam logic [REG_W-1:0] FLOOR_RESET        = 12'd30;

  // One channel's state, stored as a single memory row.
  typedef struct packed {
    logic [FILL_W-1:0]   fill;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
    logic [SAMPLE_W-1:0] held;
  } row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                done;
    logic                rejected;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/block_average_spread_reject.sv @@
// Per-channel block averager with spread rejection.
// Input channel: channel_i and sample_i under in_valid_i / in_stall_o. An item
// is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: level_o, window_done_o and window_rejected_o under
// out_valid_o / out_stall_i. Every input item gives exactly one result item.
// The edge that takes an item reads the channel's row from the state memory
// into the read stage; the edge that moves it on updates the row and loads the
// output register. One item per cycle is sustained while the receiver does not
// stall, also for the same channel twice in a row, because the row just written
// is forwarded into the read stage.
// Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write spread_limit (index
// 0) and floor (index 1); write them only while no item is in flight.
// Reset loads spread_limit 300 and floor 30 and clears one valid flag per
// channel row, so all counts, sums and held averages read as zero at once; no
// clearing pass is needed. When the receiver stalls, the output register holds
// its item, one more item can wait in the read stage, and then in_stall_o rises.
// Items with a channel number at or beyond the configured count leave the state
// alone and report zero.

`default_nettype none

module block_average_spread_reject #(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned CHANNELS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bas_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [bas_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    channel_i,
  input  logic [bas_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bas_pkg::SAMPLE_W-1:0]  level_o,
  output logic                          window_done_o,
  output logic                          window_rejected_o
);
  import bas_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0]  CH_LIMIT = 4'(CHANNELS);

  row_t mem [CHANNELS];
  row_t rd_q;

  logic [CHANNELS-1:0] row_vld_q;
  logic [REG_W-1:0]    spread_limit_q;
  logic [REG_W-1:0]    floor_q;

  logic                s1_vld_q;
  logic [AW-1:0]       s1_addr_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_inr_q;
  logic                s1_rvld_q;
  logic                s1_fwd_q;
  row_t                s1_fwd_row_q;

  logic                out_vld_q;
  res_t                out_res_q;

  logic [2:0]    ch_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic          in_accept;
  logic          advance;
  logic          s1_go;
  logic          wr_en;
  row_t          cur_row;
  row_t          new_row;
  res_t          res;

  assign ch_ext   = {1'b0, channel_i};
  assign in_addr  = ch_ext[AW-1:0];
  assign in_range = ({2'b00, channel_i} < CH_LIMIT);

  assign advance    = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && advance;
  assign in_stall_o = s1_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = s1_go && s1_inr_q;

  // A row that was written at the edge of the read is newer than the read data.
  assign cur_row = s1_fwd_q ? s1_fwd_row_q : (s1_rvld_q ? rd_q : '0);

  bas_update #(
    .WINDOW(WINDOW)
  ) u_update (
    .row_i         (cur_row),
    .sample_i      (s1_sample_q),
    .spread_limit_i(spread_limit_q),
    .floor_i       (floor_q),
    .row_o         (new_row),
    .res_o         (res)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= new_row;
    end
    if (in_accept && in_range) begin
      rd_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q      <= '0;
      spread_limit_q <= SPREAD_LIMIT_RESET;
      floor_q        <= FLOOR_RESET;
      s1_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[s1_addr_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPREAD_LIMIT: spread_limit_q <= cfg_data_i;
          REG_FLOOR:        floor_q        <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_addr_q    <= in_addr;
      s1_sample_q  <= sample_i;
      s1_inr_q     <= in_range;
      s1_rvld_q    <= in_range && row_vld_q[in_addr];
      s1_fwd_q     <= wr_en && (s1_addr_q == in_addr);
      s1_fwd_row_q <= new_row;
    end
    if (s1_go) begin
      out_res_q <= s1_inr_q ? res : '0;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign level_o           = out_res_q.level;
  assign window_done_o     = out_res_q.done;
  assign window_rejected_o = out_res_q.rejected;

endmodule

`default_nettype wire

@@ rtl/bas_update.sv @@
`default_nettype none

module bas_update #(
  parameter int unsigned WINDOW = 16
) (
  input  bas_pkg::row_t                      row_i,
  input  logic [bas_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [bas_pkg::REG_W-1:0]          spread_limit_i,
  input  logic [bas_pkg::REG_W-1:0]          floor_i,
  output bas_pkg::row_t                      row_o,
  output bas_pkg::res_t                      res_o
);
  import bas_pkg::*;

  // The mean is the sum times a rounded-up reciprocal of WINDOW. With the shift
  // at least the sum width plus log2 of WINDOW the quotient is exact.
  localparam int unsigned RECIP_SHIFT = SUM_W + FILL_W;
  localparam int unsigned RECIP       = ((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned PROD_W      = SUM_W + RECIP_SHIFT;

  logic                first;
  logic [SAMPLE_W-1:0] nmin;
  logic [SAMPLE_W-1:0] nmax;
  logic [SUM_W-1:0]    nsum;
  logic [FILL_W-1:0]   nfill;
  logic                done;
  logic [SAMPLE_W-1:0] spread;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] mean;
  logic                rejected;
  logic [SAMPLE_W-1:0] nheld;

  assign first  = (row_i.fill == '0);
  assign nmin   = (first || (sample_i < row_i.min)) ? sample_i : row_i.min;
  assign nmax   = (first || (sample_i > row_i.max)) ? sample_i : row_i.max;
  assign nsum   = row_i.sum + SUM_W'(sample_i);
  assign nfill  = row_i.fill + FILL_W'(1);
  assign done   = (nfill >= FILL_W'(WINDOW));
  assign spread = nmax - nmin;
  assign prod   = PROD_W'(nsum) * PROD_W'(RECIP);
  assign mean   = prod[RECIP_SHIFT +: SAMPLE_W];

  assign rejected = done && (spread > spread_limit_i);
  assign nheld    = (done && !rejected) ? mean : row_i.held;

  always_comb begin
    row_o.fill = done ? '0 : nfill;
    row_o.sum  = done ? '0 : nsum;
    row_o.min  = nmin;
    row_o.max  = nmax;
    row_o.held = nheld;
  end

  always_comb begin
    res_o.level    = (nheld > floor_i) ? nheld : '0;
    res_o.done     = done;
    res_o.rejected = rejected;
  end

endmodule

`default_nettype wire

@@ rtl/bas_checker.sv @@
`default_nettype none

`include "block_average_spread_reject_defines.svh"

module bas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] level_o,
  input logic        window_done_o,
  input logic        window_rejected_o
);

  logic [13:0] out_fields;
  logic        in_take;

  assign out_fields = {level_o, window_done_o, window_rejected_o};
  assign in_take    = in_valid_i && !in_stall_o;

  // A stalled result item stays in place with all of its fields.
  `BAS_ASSERT_NEXT(a_out_hold, (out_valid_o && out_stall_i), (out_valid_o && $stable(out_fields)))

  // Only a completed window can be rejected.
  `BAS_ASSERT(a_reject_needs_done, (!out_valid_o || !window_rejected_o || window_done_o))

  // With the output register empty the block always takes the next item.
  `BAS_ASSERT(a_no_stall_when_empty, (!out_valid_o |-> !in_stall_o))

  // An accepted item reaches the output through the read stage unless the output is stalled.
  `BAS_ASSERT_NEXT(a_latency, (in_take ##1 !(out_valid_o && out_stall_i)), out_valid_o)

endmodule

bind block_average_spread_reject bas_checker u_bas_checker (.*);

`default_nettype wire
